[src/fat16_cluster_chain_engine_assert.svh]
// ============================================================================
// fat16 cluster chain engine assertion macros
// concurrent checks, compiled out for synthesis
// ============================================================================
`ifndef FAT16_CLUSTER_CHAIN_ENGINE_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define FCC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define FCC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define FCC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define FCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[src/fcc_pkg.sv]
// ============================================================================
// fcc_pkg
// shared types and constants of the fat16 cluster chain engine
// ============================================================================
`timescale 1ns / 1ps

package fcc_pkg;

    localparam int ENTRY_W         = 16;
    localparam int NUM_W           = 17;
    localparam int CFG_W           = 13;
    localparam int KIND_W          = 3;
    localparam int MAX_ENTRIES_DEF = 4096;
    localparam int CFG_RESET       = 4096;

    localparam logic [ENTRY_W-1:0] EOC_MARK   = 16'hFFFF;
    localparam logic [ENTRY_W-1:0] EOC_MIN    = 16'hFFF8;
    localparam logic [ENTRY_W-1:0] BAD_MIN    = 16'hFFF7;
    localparam logic [ENTRY_W-1:0] FREE_ENTRY = 16'h0000;
    localparam logic [ENTRY_W-1:0] FIRST_DATA = 16'h0002;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_READ   = 3'd1,
        KIND_WALK   = 3'd2,
        KIND_ALLOC  = 3'd3,
        KIND_EXTEND = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_WALK_CHK,
        ST_WALK_RD,
        ST_SCAN,
        ST_LINK,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic               rd_en;
        logic [ENTRY_W-1:0] rd_addr;
        logic               wr_en;
        logic [ENTRY_W-1:0] wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] cluster;
        status_t            status;
    } result_t;

endpackage

[src/fat16_cluster_chain_engine.sv]
// ============================================================================
// fat16_cluster_chain_engine
// states: load, unknown kind, no scan: dispatch, final; read: dispatch, read, final
// walk: check, read per link; allocate: scan from entry 2; extend: scan, link a free entry
// one item at a time: the next beat is accepted in idle, after the result beat is registered
// a stalled result beat holds the engine in its final state until the output register frees
// reset clears control, entries_reg to min(4096, MAX_ENTRIES); table undefined until loaded
// ============================================================================
`timescale 1ns / 1ps

module fat16_cluster_chain_engine #(
    parameter int MAX_ENTRIES = fcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fcc_pkg::KIND_W-1:0]     kind,
    input  logic [fcc_pkg::ENTRY_W-1:0]    index,
    input  logic [fcc_pkg::ENTRY_W-1:0]    value,
    input  logic [fcc_pkg::ENTRY_W-1:0]    count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fcc_pkg::ENTRY_W-1:0]    cluster,
    output logic                           end_of_chain,
    output logic                           cluster_usable,
    output logic [1:0]                     status,
    input  logic                           cfg_we,
    input  logic [fcc_pkg::CFG_W-1:0]      cfg_wdata
);
    import fcc_pkg::*;

    localparam logic [NUM_W-1:0] ENTRY_LIM = NUM_W'(MAX_ENTRIES);
    localparam logic [NUM_W-1:0] ENTRY_RST =
        (CFG_RESET < MAX_ENTRIES) ? NUM_W'(CFG_RESET) : ENTRY_LIM;

    logic [NUM_W-1:0]   entries_reg;
    logic [NUM_W-1:0]   entries_next;
    logic [NUM_W-1:0]   cfg_ext;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ENTRY_W-1:0] cluster_reg;
    logic               eoc_reg;
    logic               usable_reg;
    status_t            status_reg;
    logic               out_ready;
    logic               load_out;
    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] rd_data;
    result_t            res;

    // table size in use, clamped to the storage depth
    assign cfg_ext      = NUM_W'(cfg_wdata);
    assign entries_next = cfg_we ? ((cfg_ext > ENTRY_LIM) ? ENTRY_LIM : cfg_ext) : entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= ENTRY_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entries_reg   <= entries_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_ready      = !out_valid_reg || !out_stall;
    assign load_out       = res.valid && out_ready;
    assign out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);

    // output beat register with flags
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cluster_reg <= res.cluster;
            eoc_reg     <= res.cluster >= EOC_MIN;
            usable_reg  <= (res.cluster >= FIRST_DATA) && (res.cluster < BAD_MIN)
                           && ({1'b0, res.cluster} < entries_reg);
            status_reg  <= res.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cluster        = cluster_reg;
    assign end_of_chain   = eoc_reg;
    assign cluster_usable = usable_reg;
    assign status         = status_reg;

    fcc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .index    (index),
        .value    (value),
        .count    (count),
        .entries  (entries_reg),
        .out_ready(out_ready),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .res      (res)
    );

    fcc_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

[src/fcc_table.sv]
// ============================================================================
// fcc_table
// link table storage, one write and one registered read per cycle
// ============================================================================
`timescale 1ns / 1ps

module fcc_table #(
    parameter int MAX_ENTRIES = fcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  fcc_pkg::mem_req_t              mem_req,
    output logic [fcc_pkg::ENTRY_W-1:0]    rd_data
);
    import fcc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [ENTRY_W-1:0] link_mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            link_mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data_reg <= link_mem[mem_req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/fcc_seq.sv]
// ============================================================================
// fcc_seq
// item sequencer: dispatch, link walk and free entry scan over the table
// ============================================================================
`timescale 1ns / 1ps
`include "fat16_cluster_chain_engine_assert.svh"

module fcc_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fcc_pkg::KIND_W-1:0]     kind,
    input  logic [fcc_pkg::ENTRY_W-1:0]    index,
    input  logic [fcc_pkg::ENTRY_W-1:0]    value,
    input  logic [fcc_pkg::ENTRY_W-1:0]    count,
    input  logic [fcc_pkg::NUM_W-1:0]      entries,
    input  logic                           out_ready,
    output fcc_pkg::mem_req_t              mem_req,
    input  logic [fcc_pkg::ENTRY_W-1:0]    rd_data,
    output fcc_pkg::result_t               res
);
    import fcc_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [ENTRY_W-1:0] index_reg;
    logic [ENTRY_W-1:0] value_reg;
    logic [ENTRY_W-1:0] count_reg;
    logic [ENTRY_W-1:0] count_next;
    logic [ENTRY_W-1:0] scan_reg;
    logic [ENTRY_W-1:0] scan_next;
    logic [ENTRY_W-1:0] res_reg;
    logic [ENTRY_W-1:0] res_next;
    status_t            stat_reg;
    status_t            stat_next;

    logic               accept;
    logic               idx_ok;
    logic               n_small;
    logic               walk_go;
    logic               hit;
    logic               scan_last;
    logic [NUM_W-1:0]   scan_inc;

    assign accept    = in_valid && !in_stall;
    assign idx_ok    = {1'b0, index_reg} < entries;
    assign n_small   = entries < (NUM_W'(FIRST_DATA) + NUM_W'(1));
    assign walk_go   = (count_reg != '0) && (res_reg != EOC_MARK)
                       && ({1'b0, res_reg} < entries);
    assign hit       = rd_data == FREE_ENTRY;
    assign scan_inc  = {1'b0, scan_reg} + NUM_W'(1);
    assign scan_last = scan_inc >= entries;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            index_reg <= index;
            value_reg <= value;
        end
        count_reg <= accept ? count : count_next;
        scan_reg  <= scan_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (kind_reg)
                    KIND_READ:   state_next = idx_ok ? ST_READ : ST_FIN;
                    KIND_WALK:   state_next = ST_WALK_CHK;
                    KIND_ALLOC:  state_next = n_small ? ST_FIN : ST_SCAN;
                    KIND_EXTEND: state_next = (idx_ok && !n_small) ? ST_SCAN : ST_FIN;
                    default:     state_next = ST_FIN;
                endcase
            end
            ST_READ:     state_next = ST_FIN;
            ST_WALK_CHK: state_next = walk_go ? ST_WALK_RD : ST_FIN;
            ST_WALK_RD:  state_next = ST_WALK_CHK;
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = (kind_reg == KIND_EXTEND) ? ST_LINK : ST_FIN;
                end
                else if (scan_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_LINK:     state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // handshake and table access
    always_comb
    begin
        in_stall        = (state_reg != ST_IDLE);
        mem_req         = '0;
        res.valid       = (state_reg == ST_FIN);
        res.cluster     = res_reg;
        res.status      = stat_reg;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                unique case (kind_reg)
                    KIND_LOAD:
                    begin
                        mem_req.wr_en   = idx_ok;
                        mem_req.wr_addr = index_reg;
                        mem_req.wr_data = value_reg;
                    end
                    KIND_READ:
                    begin
                        mem_req.rd_en   = idx_ok;
                        mem_req.rd_addr = index_reg;
                    end
                    KIND_ALLOC:
                    begin
                        mem_req.rd_en   = !n_small;
                        mem_req.rd_addr = FIRST_DATA;
                    end
                    KIND_EXTEND:
                    begin
                        mem_req.rd_en   = idx_ok && !n_small;
                        mem_req.rd_addr = FIRST_DATA;
                    end
                    default:
                    begin
                        mem_req = '0;
                    end
                endcase
            end
            ST_WALK_CHK:
            begin
                mem_req.rd_en   = walk_go;
                mem_req.rd_addr = res_reg;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    mem_req.wr_en = 1'b1;
                    if (kind_reg == KIND_EXTEND)
                    begin
                        mem_req.wr_addr = index_reg;
                        mem_req.wr_data = scan_reg;
                    end
                    else
                    begin
                        mem_req.wr_addr = scan_reg;
                        mem_req.wr_data = EOC_MARK;
                    end
                end
                else
                begin
                    mem_req.rd_en   = !scan_last;
                    mem_req.rd_addr = scan_inc[ENTRY_W-1:0];
                end
            end
            ST_LINK:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = scan_reg;
                mem_req.wr_data = EOC_MARK;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

    // result datapath
    always_comb
    begin
        count_next = count_reg;
        scan_next  = scan_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        case (state_reg)
            ST_DISPATCH:
            begin
                stat_next = STAT_OK;
                res_next  = '0;
                scan_next = FIRST_DATA;
                case (kind_reg)
                    KIND_LOAD:
                    begin
                        if (idx_ok)
                        begin
                            res_next = value_reg;
                        end
                        else
                        begin
                            stat_next = STAT_RANGE;
                        end
                    end
                    KIND_READ:
                    begin
                        if (!idx_ok)
                        begin
                            stat_next = STAT_RANGE;
                        end
                    end
                    KIND_WALK:
                    begin
                        res_next = index_reg;
                    end
                    KIND_ALLOC:
                    begin
                        if (n_small)
                        begin
                            res_next  = EOC_MARK;
                            stat_next = STAT_FULL;
                        end
                    end
                    KIND_EXTEND:
                    begin
                        if (!idx_ok)
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else if (n_small)
                        begin
                            stat_next = STAT_FULL;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_READ:
            begin
                res_next = rd_data;
            end
            ST_WALK_CHK:
            begin
                if (walk_go)
                begin
                    count_next = count_reg - ENTRY_W'(1);
                end
                else if ((count_reg != '0) && (res_reg != EOC_MARK))
                begin
                    stat_next = STAT_RANGE;
                end
            end
            ST_WALK_RD:
            begin
                res_next = rd_data;
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next = scan_reg;
                end
                else if (scan_last)
                begin
                    res_next  = (kind_reg == KIND_EXTEND) ? FREE_ENTRY : EOC_MARK;
                    stat_next = STAT_FULL;
                end
                else
                begin
                    scan_next = scan_inc[ENTRY_W-1:0];
                end
            end
            ST_LINK:
            begin
                res_next = scan_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    `FCC_ASSERT_ALWAYS(a_one_port_op, clk, rst_n, !(mem_req.rd_en && mem_req.wr_en), "table read and write in one cycle")
    `FCC_ASSERT_NEXT(a_read_consumed, clk, rst_n, mem_req.rd_en, (state_reg == ST_READ) || (state_reg == ST_WALK_RD) || (state_reg == ST_SCAN), "table read data not consumed")
    `FCC_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, accept, state_reg == ST_DISPATCH, "accepted beat not dispatched")
    `FCC_ASSERT_IMPLIES(a_scan_in_table, clk, rst_n, state_reg == ST_SCAN, {1'b0, scan_reg} < entries, "free scan outside table")

endmodule
